@@ src/sv39ptm_pkg.sv @@
package sv39ptm_pkg;

  // Default number of store pages
  localparam int TABLE_PAGES_DEF = 64;

  // Sv39 geometry
  localparam int IDX_W   = 9;
  localparam int VPN_W   = 27;
  localparam int PPN_W   = 44;
  localparam int PTE_W   = 64;
  localparam int TOP_W   = 10;
  localparam int CNT_W   = 16;
  localparam int PERM_W  = 4;
  localparam int ALLOC_W = 6;
  localparam int ROOT_W  = 6;
  localparam int CFG_W   = 64;

  // Walk levels
  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TABLE_BASE = 1'b0;
  localparam logic CFG_ROOT_PAGE  = 1'b1;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_READ,
    OP_FOLLOW,
    OP_LINK,
    OP_LEAF,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] lvl;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic count_done;
    logic root_bad;
    logic entry_valid;
    logic outside;
    logic full;
  } dp_sts_t;

endpackage

@@ src/sv39ptm_dp.sv @@
module sv39ptm_dp import sv39ptm_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [VPN_W-1:0]    virtual_page_i,
  input  logic [PPN_W-1:0]    physical_page_i,
  input  logic [CNT_W-1:0]    page_count_i,
  input  logic [PERM_W-1:0]   permissions_i,
  output logic [1:0]          status_o,
  output logic [CNT_W-1:0]    pages_mapped_o,
  output logic [ALLOC_W-1:0]  tables_allocated_o,
  output logic [PTE_W-1:0]    last_leaf_entry_o
);

  localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NFW   = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);

  // Control and configuration state
  logic [PPN_W-1:0]  base_q;
  logic [ROOT_W-1:0] root_q;
  logic [NFW-1:0]    nfp_q;
  logic [AW-1:0]     clr_q;

  // Request payload
  logic [VPN_W-1:0]   vp_q;
  logic [PPN_W-1:0]   pp_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   mapped_q;
  logic [PERM_W-1:0]  perm_q;
  logic [ALLOC_W-1:0] allocs_q;
  logic [PTE_W-1:0]   last_q;
  logic [1:0]         status_q;
  logic [PW-1:0]      cur_page_q;
  logic [AW-1:0]      addr_q;
  logic [PTE_W-1:0]   rdata_q;

  logic [PTE_W-1:0]   mem_q [DEPTH];

  logic [PW-1:0]      rd_page;
  logic [IDX_W-1:0]   rd_idx;
  logic [AW-1:0]      rd_addr;
  logic [PPN_W-1:0]   rel;
  logic [PPN_W-1:0]   new_ppn;
  logic [PTE_W-1:0]   link_entry;
  logic [PTE_W-1:0]   leaf_entry;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [PTE_W-1:0]   mem_wdata;

  // Pick the table page and index for the level being read
  always_comb begin
    rd_page = (cmd_i.lvl == LVL_ROOT) ? PW'(root_q) : cur_page_q;
    case (cmd_i.lvl)
      LVL_ROOT: rd_idx = vp_q[3*IDX_W-1:2*IDX_W];
      LVL_MID:  rd_idx = vp_q[2*IDX_W-1:IDX_W];
      default:  rd_idx = vp_q[IDX_W-1:0];
    endcase
  end
  assign rd_addr = {rd_page, rd_idx};

  // Entry decode and new entry values
  assign rel        = rdata_q[PPN_W+TOP_W-1:TOP_W] - base_q;
  assign new_ppn    = base_q + PPN_W'(nfp_q);
  assign link_entry = {rdata_q[PTE_W-1:PTE_W-TOP_W], new_ppn, 9'd0, 1'b1};
  assign leaf_entry = {rdata_q[PTE_W-1:PTE_W-TOP_W], pp_q, 5'd0, perm_q, 1'b1};

  always_comb begin
    sts_o.clr_last    = (clr_q == AW'(DEPTH - 1));
    sts_o.count_done  = (mapped_q == count_q);
    sts_o.root_bad    = (32'(root_q) >= 32'(TABLE_PAGES));
    sts_o.entry_valid = rdata_q[0];
    sts_o.outside     = (rel >= PPN_W'(TABLE_PAGES));
    sts_o.full        = (32'(nfp_q) >= 32'(TABLE_PAGES));
  end

  // Steer the single store port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = leaf_entry;
    case (cmd_i.op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      OP_READ: begin
        mem_re   = 1'b1;
        mem_addr = rd_addr;
      end
      OP_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = link_entry;
      end
      OP_LEAF: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Table store with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // Configuration, bump counter and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      root_q <= '0;
      nfp_q  <= NFW'(1);
      clr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TABLE_BASE: base_q <= cfg_data_i[PPN_W-1:0];
          CFG_ROOT_PAGE:  root_q <= cfg_data_i[ROOT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_LINK) begin
        nfp_q <= nfp_q + NFW'(1);
      end
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Request registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        vp_q     <= virtual_page_i;
        pp_q     <= physical_page_i;
        count_q  <= page_count_i;
        perm_q   <= permissions_i;
        mapped_q <= '0;
        allocs_q <= '0;
        last_q   <= '0;
      end
      OP_READ: begin
        addr_q <= rd_addr;
      end
      OP_FOLLOW: begin
        cur_page_q <= rel[PW-1:0];
      end
      OP_LINK: begin
        cur_page_q <= nfp_q[PW-1:0];
        if (allocs_q != '1) begin
          allocs_q <= allocs_q + ALLOC_W'(1);
        end
      end
      OP_LEAF: begin
        last_q   <= leaf_entry;
        mapped_q <= mapped_q + CNT_W'(1);
        vp_q     <= vp_q + VPN_W'(1);
        pp_q     <= pp_q + PPN_W'(1);
      end
      OP_FINISH: begin
        status_q <= cmd_i.code;
      end
      default: ;
    endcase
  end

  assign status_o           = status_q;
  assign pages_mapped_o     = mapped_q;
  assign tables_allocated_o = allocs_q;
  assign last_leaf_entry_o  = last_q;

endmodule

@@ src/sv39ptm_ctrl.sv @@
module sv39ptm_ctrl import sv39ptm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NEXT,
    S_READ,
    S_EVAL
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic       done_q, done_d;

  // Sequence one page walk per pass through NEXT
  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    done_d    = 1'b0;
    cmd_o.op   = OP_IDLE;
    cmd_o.lvl  = lvl_q;
    cmd_o.code = ST_DONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.count_done) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_DONE;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else if (sts_i.root_bad) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_OUTSIDE;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.op  = OP_READ;
          cmd_o.lvl = LVL_ROOT;
          lvl_d     = LVL_ROOT;
          state_d   = S_EVAL;
        end
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (lvl_q == LVL_LEAF) begin
          cmd_o.op = OP_LEAF;
          state_d  = S_NEXT;
        end else if (sts_i.entry_valid) begin
          if (sts_i.outside) begin
            cmd_o.op   = OP_FINISH;
            cmd_o.code = ST_OUTSIDE;
            done_d     = 1'b1;
            state_d    = S_IDLE;
          end else begin
            cmd_o.op = OP_FOLLOW;
            lvl_d    = lvl_q - 2'd1;
            state_d  = S_READ;
          end
        end else if (sts_i.full) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_FULL;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.op = OP_LINK;
          lvl_d    = lvl_q - 2'd1;
          state_d  = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, level and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      lvl_q   <= LVL_ROOT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ src/sv39_page_table_mapper.sv @@
// Walk: each page mapped is one pass from NEXT through root, middle and leaf evaluation; a walk
//   that stops on a failing table read raises done in the cycle after that read is evaluated.
// Requests: one request at a time; each page uses the single store port for a read and a
//   possible update at root, middle and leaf level.
// Reset: the table store is swept to zero, one entry a cycle, over all TABLE_PAGES*512 entries
//   (32768 by default) with busy high; done is strobed for one cycle and the results hold until the next request.
module sv39_page_table_mapper import sv39ptm_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [VPN_W-1:0]    virtual_page_i,
  input  logic [PPN_W-1:0]    physical_page_i,
  input  logic [CNT_W-1:0]    page_count_i,
  input  logic [PERM_W-1:0]   permissions_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [CNT_W-1:0]    pages_mapped_o,
  output logic [ALLOC_W-1:0]  tables_allocated_o,
  output logic [PTE_W-1:0]    last_leaf_entry_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  sv39ptm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  sv39ptm_dp #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .virtual_page_i    (virtual_page_i),
    .physical_page_i   (physical_page_i),
    .page_count_i      (page_count_i),
    .permissions_i     (permissions_i),
    .status_o          (status_o),
    .pages_mapped_o    (pages_mapped_o),
    .tables_allocated_o(tables_allocated_o),
    .last_leaf_entry_o (last_leaf_entry_o)
  );

  // A result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe held for more than one cycle");

  // An accepted request keeps the block busy until its result
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request accepted without going busy");

  // Only defined status codes are reported
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_DONE || status_o == ST_FULL || status_o == ST_OUTSIDE))
    else $error("undefined status code");

  // A completed request with pages mapped reports a valid leaf
  a_leaf_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pages_mapped_o != '0) |-> last_leaf_entry_o[0])
    else $error("last leaf entry not valid");

endmodule
